// File: hdl/parabolic_minimum_search_step_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the parabolic minimum search step
// Concurrent checks, empty when synthesized.
// ----------------------------------------------------------------------------
`ifndef PARABOLIC_MINIMUM_SEARCH_STEP_DEFINES_SVH
`define PARABOLIC_MINIMUM_SEARCH_STEP_DEFINES_SVH
`ifndef SYNTHESIS
`define PMS_ASSERT_NOW(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("pms check failed");
`define PMS_ASSERT_NEXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("pms check failed");
`else
`define PMS_ASSERT_NOW(lbl, a, c)
`define PMS_ASSERT_NEXT(lbl, a, c)
`endif
`endif

// File: hdl/pms_pkg.sv
// ----------------------------------------------------------------------------
// Parabolic minimum search package
// Format, reset and register index constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package pms_pkg;
	localparam int VALUE_WIDTH  = 32;
	localparam int FRAC_BITS    = 16;
	localparam longint CENTER_RESET = longint'(1) << FRAC_BITS;
	localparam longint STEP_RESET   = longint'(1) << (FRAC_BITS - 2);
	localparam int USE_FACTOR   = 200;
	localparam int CFG_INDEX_W  = 2;
	localparam logic [CFG_INDEX_W-1:0] REG_START_CENTER = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_START_STEP   = 2'd1;
endpackage

// File: hdl/parabolic_minimum_search_step.sv
// ----------------------------------------------------------------------------
// Parabolic minimum search step
// Fits a parabola through three error samples, moves the center to its
// minimum (or by at most one step when the vertex is not interpolated),
// rescales the step and issues the next three trial points. The
// interpolated vertex takes two passes of the shared bit-serial
// multiply-divide unit; the other cases skip it. The next item is taken
// the cycle after the result loads, later while a held result blocks the
// output register.
// Reset: async, active low; center 1.0 and step 0.25, no result pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "parabolic_minimum_search_step_defines.svh"
module parabolic_minimum_search_step #(
	parameter int VW = pms_pkg::VALUE_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pms_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [VW-1:0]                  cfg_data,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// err_below, err_middle, err_above
	input  logic [((3*VW+7)/8)*8-1:0]      s_axis_tdata,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// best_value, best_location, trial_low, trial_mid, trial_high
	output logic [((5*VW+7)/8)*8-1:0]      m_axis_tdata,
	// inside_bracket, step_still_useful
	output logic [1:0]                     m_axis_tuser
);
	import pms_pkg::*;

	localparam int RW = VW + 6;
	localparam int CW = $clog2(VW + 2);
	localparam int IW = ((3*VW+7)/8)*8;
	localparam int OW = ((5*VW+7)/8)*8;
	localparam int PW = VW + 7;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_PREP  = 9'b000000010,
		S_CLASS = 9'b000000100,
		S_DIV   = 9'b000001000,
		S_FIN   = 9'b000010000,
		S_TRIAL = 9'b000100000,
		S_SHIFT = 9'b001000000,
		S_USE   = 9'b010000000,
		S_DONE  = 9'b100000000
	} state_t;

	typedef enum logic [1:0] {
		K_NEG   = 2'd0,
		K_ZERO  = 2'd1,
		K_CLAMP = 2'd2,
		K_DIV   = 2'd3
	} kind_t;

	function automatic logic signed [VW-1:0] sat(input logic signed [VW+1:0] v);
		logic signed [VW-1:0] r;
		if (v[VW+1:VW-1] == 3'b000 || v[VW+1:VW-1] == 3'b111)
			r = v[VW-1:0];
		else if (v[VW+1])
			r = {1'b1, {(VW-1){1'b0}}};
		else
			r = {1'b0, {(VW-1){1'b1}}};
		return r;
	endfunction

	state_t               state_q;
	kind_t                kind_q;
	logic signed [VW-1:0] e0_q, e1_q, e2_q;
	logic signed [VW:0]   num_q;
	logic signed [VW+1:0] den_q;
	logic signed [VW-1:0] center_q;
	logic [VW-2:0]        step_q;
	logic [VW:0]          a_q, n_q, q_q, m_q, drop_q;
	logic [RW-1:0]        d_q, r_q;
	logic [CW-1:0]        cnt_q;
	logic                 pass_q;
	logic signed [VW-1:0] val_q, loc_q, low_q, mid_q, high_q;
	logic                 inside_q, useful_q;
	logic                 m_valid_q;
	logic [OW-1:0]        m_data_q;
	logic [1:0]           m_user_q;

	logic [VW:0]          an;
	logic [RW-1:0]        den2, den8, t;
	logic [RW:0]          d2;
	logic [VW:0]          q_next;
	logic [RW-1:0]        r_next;
	kind_t                kind_d;
	logic signed [VW+1:0] shift;
	logic signed [VW-1:0] val_d;
	logic                 inside_d;
	logic                 sel_lo, sel_hi;
	logic [PW-1:0]        prod;
	logic [VW-1:0]        abs_c;
	logic                 load_out;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;
	assign load_out      = (state_q == S_DONE) && (!m_valid_q || m_axis_tready);

	assign an   = num_q[VW] ? (VW+1)'(0) - num_q : num_q;
	assign den2 = RW'(den_q) << 1;
	assign den8 = RW'(den_q) << 3;

	always_comb begin
		if (den_q[VW+1])
			kind_d = K_NEG;
		else if (step_q == '0 || num_q == '0)
			kind_d = K_ZERO;
		else if (den_q == '0 || RW'(an) > den2)
			kind_d = K_CLAMP;
		else
			kind_d = K_DIV;
	end

	assign t      = {r_q[RW-2:0], 1'b0} + (a_q[VW] ? RW'(n_q) : RW'(0));
	assign d2     = {d_q, 1'b0};
	always_comb begin
		if ({1'b0, t} >= d2) begin
			r_next = t - d2[RW-1:0];
			q_next = {q_q[VW-1:0], 1'b0} + (VW+1)'(2);
		end else if (t >= d_q) begin
			r_next = t - d_q;
			q_next = {q_q[VW-1:0], 1'b0} + (VW+1)'(1);
		end else begin
			r_next = t;
			q_next = {q_q[VW-1:0], 1'b0};
		end
	end

	always_comb begin
		sel_lo = 1'b0;
		sel_hi = 1'b0;
		shift  = '0;
		val_d  = e1_q;
		inside_d = 1'b1;
		case (kind_q)
			K_NEG: begin
				inside_d = 1'b0;
				if (e2_q < e0_q && e2_q < e1_q)
					sel_hi = 1'b1;
				else if (!(e1_q < e0_q))
					sel_lo = 1'b1;
				if (sel_hi) begin
					shift = (VW+2)'(step_q);
					val_d = e2_q;
				end else if (sel_lo) begin
					shift = -(VW+2)'(step_q);
					val_d = e0_q;
				end
			end
			K_CLAMP: begin
				inside_d = 1'b0;
				if (num_q[VW]) begin
					shift = -(VW+2)'(step_q);
					val_d = e0_q;
				end else begin
					shift = (VW+2)'(step_q);
					val_d = e2_q;
				end
			end
			K_DIV: begin
				shift = num_q[VW] ? -(VW+2)'(m_q) : (VW+2)'(m_q);
				val_d = sat((VW+2)'(e1_q) - (VW+2)'(drop_q));
			end
			default: begin
				shift = '0;
			end
		endcase
	end

	assign prod  = PW'(step_q) * PW'(USE_FACTOR);
	assign abs_c = center_q[VW-1] ? VW'(0) - VW'(center_q) : VW'(center_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			center_q  <= VW'(CENTER_RESET);
			step_q    <= (VW-1)'(STEP_RESET);
			m_valid_q <= 1'b0;
		end else begin
			if (m_valid_q && m_axis_tready)
				m_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid)
						state_q <= S_PREP;
				end
				S_PREP:  state_q <= S_CLASS;
				S_CLASS: state_q <= (kind_d == K_DIV) ? S_DIV : S_FIN;
				S_DIV: begin
					if (cnt_q == '0 && pass_q)
						state_q <= S_FIN;
				end
				S_FIN: begin
					state_q  <= S_TRIAL;
					center_q <= sat((VW+2)'(center_q) + shift);
					if (inside_d)
						step_q <= step_q >> 1;
					else if (step_q[VW-2])
						step_q <= '1;
					else
						step_q <= {step_q[VW-3:0], 1'b0};
				end
				S_TRIAL: state_q <= S_SHIFT;
				S_SHIFT: begin
					state_q <= S_USE;
					if (low_q[VW-1])
						center_q <= sat((VW+2)'(mid_q) - (VW+2)'(low_q));
				end
				S_USE: state_q <= S_DONE;
				S_DONE: begin
					if (load_out) begin
						state_q   <= S_IDLE;
						m_valid_q <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (cfg_valid) begin
				if (cfg_index == REG_START_CENTER)
					center_q <= cfg_data;
				else if (cfg_index == REG_START_STEP)
					step_q <= cfg_data[VW-2:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				e0_q <= s_axis_tdata[VW-1:0];
				e1_q <= s_axis_tdata[2*VW-1:VW];
				e2_q <= s_axis_tdata[3*VW-1:2*VW];
			end
			S_PREP: begin
				num_q <= (VW+1)'(e0_q) - (VW+1)'(e2_q);
				den_q <= (VW+2)'(e0_q) - ((VW+2)'(e1_q) <<< 1) + (VW+2)'(e2_q);
			end
			S_CLASS: begin
				kind_q <= kind_d;
				a_q    <= (VW+1)'(step_q);
				n_q    <= an;
				d_q    <= den2;
				r_q    <= '0;
				q_q    <= '0;
				cnt_q  <= CW'(VW);
				pass_q <= 1'b0;
			end
			S_DIV: begin
				if (cnt_q == '0) begin
					if (pass_q)
						drop_q <= q_next;
					else
						m_q <= q_next;
					a_q    <= n_q;
					d_q    <= den8;
					r_q    <= '0;
					q_q    <= '0;
					cnt_q  <= CW'(VW);
					pass_q <= 1'b1;
				end else begin
					a_q   <= {a_q[VW-1:0], 1'b0};
					r_q   <= r_next;
					q_q   <= q_next;
					cnt_q <= cnt_q - CW'(1);
				end
			end
			S_FIN: begin
				val_q    <= val_d;
				loc_q    <= sat((VW+2)'(center_q) + shift);
				inside_q <= inside_d;
			end
			S_TRIAL: begin
				low_q  <= sat((VW+2)'(center_q) - (VW+2)'(step_q));
				mid_q  <= center_q;
				high_q <= sat((VW+2)'(center_q) + (VW+2)'(step_q));
			end
			S_SHIFT: begin
				if (low_q[VW-1]) begin
					mid_q  <= sat((VW+2)'(mid_q) - (VW+2)'(low_q));
					high_q <= sat((VW+2)'(high_q) - (VW+2)'(low_q));
					low_q  <= '0;
				end
			end
			S_USE: begin
				useful_q <= prod > PW'(abs_c);
			end
			S_DONE: begin
				if (load_out) begin
					m_data_q <= OW'({high_q, mid_q, low_q, loc_q, val_q});
					m_user_q <= {useful_q, inside_q};
				end
			end
			default: begin
				val_q <= val_q;
			end
		endcase
	end

	`PMS_ASSERT_NOW(a_busy_not_ready, state_q != S_IDLE, !s_axis_tready)
	`PMS_ASSERT_NEXT(a_div_to_fin, state_q == S_DIV && cnt_q == '0 && pass_q, state_q == S_FIN)
	`PMS_ASSERT_NEXT(a_load_shows, load_out, m_axis_tvalid && state_q == S_IDLE)
endmodule
